// ----- rtl/core/key_press_edge_capture_top_assert.svh -----
// Assertion macros shared by the key press edge capture RTL.
`ifndef KEY_PRESS_EDGE_CAPTURE_TOP_ASSERT_SVH
`define KEY_PRESS_EDGE_CAPTURE_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define KPEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define KPEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/kpec_pkg.sv -----
// Package with request codes, scan result type and the take-first search order.
package kpec_pkg;

    localparam int KEY_COUNT  = 256;
    localparam int WORD_KEYS  = 32;
    localparam int WORD_COUNT = KEY_COUNT / WORD_KEYS;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_TAKE  = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [7:0] key;
    } t_scan_res;

    // Maps a position in the search order to its key code. The last
    // position holds key 0, which is never searched.
    function automatic logic [7:0] order_key(input logic [7:0] pos);
        logic [7:0] j;
        logic [7:0] k;
        begin
            j = pos - 8'd6;
            if (pos < 8'd6) begin
                k = 8'hA0 + pos;
            end else if (pos >= 8'd255) begin
                k = 8'h00;
            end else if (pos >= 8'd252) begin
                k = 8'h10 + (pos - 8'd252);
            end else if (j < 8'd15) begin
                k = j + 8'd1;
            end else if (j < 8'd156) begin
                k = j + 8'd4;
            end else begin
                k = j + 8'd10;
            end
            return k;
        end
    endfunction

endpackage

// ----- rtl/core/kpec_scan.sv -----
// Shared priority search unit: finds the first set bit of one 32-position chunk.
module kpec_scan (
    input  logic [31:0]         i_chunk,
    input  logic [2:0]          i_base,
    output kpec_pkg::t_scan_res o_res
);
    import kpec_pkg::*;

    logic [4:0] idx;

    // Lowest set bit wins, since lower positions come first in the order.
    always_comb begin
        idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (i_chunk[i]) begin
                idx = 5'(i);
            end
        end
    end

    assign o_res.hit = |i_chunk;
    assign o_res.key = order_key({i_base, idx});

endmodule

// ----- rtl/core/kpec_snap.sv -----
// Snapshot store of down flags, eight words of 32 keys, with rising-edge detect.
module kpec_snap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [2:0]  i_addr,
    input  logic [63:0] i_bits,
    input  logic [4:0]  i_bit_sel,
    output logic [31:0] o_rise,
    output logic        o_down
);
    import kpec_pkg::*;

    logic [31:0] r_down [WORD_COUNT];
    logic [31:0] new_down;
    logic [31:0] rd_word;

    // Only the low bit of each pair is ever read, so only that bit is kept.
    always_comb begin
        for (int i = 0; i < WORD_KEYS; i++) begin
            new_down[i] = i_bits[2 * i];
        end
    end

    assign rd_word = r_down[i_addr];
    assign o_rise  = new_down & ~rd_word;
    assign o_down  = rd_word[i_bit_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
                r_down[w] <= '0;
            end
        end else if (i_wr_en) begin
            r_down[i_addr] <= new_down;
        end
    end

endmodule

// ----- rtl/core/key_press_edge_capture_top.sv -----
// Top level of the key press edge capture block: sequencer, pending map and ports.
//
// Usage. A request word is accepted on a rising edge with start high and busy
// low. Its fields are the request type, the snapshot word index, the 64-bit
// snapshot word and the key to query. Every accepted word gives exactly one
// result word on o_found_key and o_key_is_down, shown for one cycle with
// o_valid high; the receiver cannot hold it off and must take it then.
// Snapshot writes, begin-capture and down queries answer in the cycle after
// acceptance and busy stays low, so such words may follow each other in
// every cycle. Take-first walks the 256-position search order in eight
// chunks of 32 through one shared priority search unit, one chunk per cycle,
// with busy high meanwhile; the result appears on the cycle after the chunk
// that holds the first pending key (or after the eighth chunk when nothing is
// pending).
// The ready register is written through its own channel (i_cfg_valid,
// o_cfg_ready, i_cfg_data); o_cfg_ready is always high. While it is zero,
// every request word is ignored and returns zeros.
// Synchronous active-low reset clears the snapshot, the pending map, the
// ready register and the sequencer; no clearing pass is needed afterwards.
module key_press_edge_capture_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_word_index,
    input  logic [63:0] i_key_bits,
    input  logic [7:0]  i_query_key,
    output logic        o_valid,
    output logic [7:0]  o_found_key,
    output logic        o_key_is_down,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import kpec_pkg::*;

`include "key_press_edge_capture_top_assert.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 r_state, n_state;
    logic [2:0]           r_cnt, n_cnt;
    logic [KEY_COUNT-1:0] r_pend, n_pend;
    logic                 r_ready;
    logic                 r_valid, n_valid;
    logic [7:0]           r_found, n_found;
    logic                 r_down, n_down;

    logic                 accept;
    logic [KEY_COUNT-1:0] order_vec;
    logic [31:0]          chunk;
    t_scan_res            scan_res;
    logic [2:0]           snap_addr;
    logic                 snap_wr;
    logic [31:0]          snap_rise;
    logic                 snap_down;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // The snapshot has one read port: queries use the key's word, writes
    // use the word being replaced.
    assign snap_addr = (i_req_type == REQ_QUERY) ? i_query_key[7:5] : i_word_index;
    assign snap_wr   = accept && r_ready && (i_req_type == REQ_WRITE);

    kpec_snap u_snap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (snap_wr),
        .i_addr    (snap_addr),
        .i_bits    (i_key_bits),
        .i_bit_sel (i_query_key[4:0]),
        .o_rise    (snap_rise),
        .o_down    (snap_down)
    );

    // The pending map rearranged into search order. This is pure wiring;
    // the last position is key 0, which the search never takes.
    generate
        for (genvar p = 0; p < KEY_COUNT - 1; p++) begin : g_order
            assign order_vec[p] = r_pend[order_key(8'(p))];
        end
    endgenerate
    assign order_vec[KEY_COUNT-1] = 1'b0;

    assign chunk = order_vec[{r_cnt, 5'd0} +: WORD_KEYS];

    kpec_scan u_scan (
        .i_chunk (chunk),
        .i_base  (r_cnt),
        .o_res   (scan_res)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_valid = 1'b0;
        n_found = 8'd0;
        n_down  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!r_ready) begin
                        n_valid = 1'b1;
                    end else begin
                        case (i_req_type)
                            REQ_WRITE: begin
                                n_pend[{i_word_index, 5'd0} +: WORD_KEYS] =
                                    r_pend[{i_word_index, 5'd0} +: WORD_KEYS] | snap_rise;
                                n_valid = 1'b1;
                            end
                            REQ_CLEAR: begin
                                n_pend  = '0;
                                n_valid = 1'b1;
                            end
                            REQ_TAKE: begin
                                n_state = ST_SCAN;
                                n_cnt   = 3'd0;
                            end
                            REQ_QUERY: begin
                                n_down  = snap_down;
                                n_valid = 1'b1;
                            end
                            default: begin
                                n_valid = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                if (scan_res.hit) begin
                    n_pend[scan_res.key] = 1'b0;
                    n_found = scan_res.key;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_cnt == 3'(WORD_COUNT - 1)) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 3'd0;
            r_pend  <= '0;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
            r_found <= 8'd0;
            r_down  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_valid <= n_valid;
            r_found <= n_found;
            r_down  <= n_down;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ready <= i_cfg_data;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_found_key   = r_found;
    assign o_key_is_down = r_down;

    // A result is only shown once the sequencer is back in idle.
    `KPEC_ASSERT_NOW(a_valid_not_busy, i_clk, i_rst_n, r_valid, !busy, "result while busy")
    // Any accepted word that does not start a search answers next cycle.
    `KPEC_ASSERT_NEXT(a_single_cycle, i_clk, i_rst_n,
        accept && !(r_ready && (i_req_type == REQ_TAKE)), r_valid, "missing result")
    // Payload is zero outside the result strobe.
    `KPEC_ASSERT_NOW(a_quiet_payload, i_clk, i_rst_n,
        !r_valid, (r_found == 8'd0) && !r_down, "payload outside strobe")
    // A search ends no later than the last chunk.
    `KPEC_ASSERT_NEXT(a_scan_bound, i_clk, i_rst_n,
        (r_state == ST_SCAN) && (r_cnt == 3'(WORD_COUNT - 1)), r_state == ST_IDLE,
        "search overran")
    // A found key has its pending bit cleared.
    `KPEC_ASSERT_NOW(a_found_cleared, i_clk, i_rst_n,
        r_valid && (r_found != 8'd0), !r_pend[r_found], "found key still pending")

endmodule
